// ----- hw/rtl/sha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash values and shared command/status types.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte    = 8'h80;
  localparam logic [5:0] LenOffset  = 6'd56;
  localparam int unsigned NumRounds = 64;

  // Controller to datapath
  typedef struct packed {
    logic       put_byte;   // write put_data at fill position, advance fill
    logic [7:0] put_data;
    logic       add_len;    // add eight to the bit length
    logic       start;      // load working vars from chain value
    logic       round;      // run one round
    logic       finish;     // fold working vars into chain value
    logic       restart;    // back to initial hash, clear fill and bit length
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [5:0]  fill;
    logic [63:0] bit_len;
    logic        last_round;
  } dp_sts_t;

endpackage

// ----- hw/rtl/sha_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, message schedule, one round per cycle, chaining value.
// ----------------------------------------------------------------------------
module sha_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sha_pkg::dp_cmd_t cmd_i,
  output sha_pkg::dp_sts_t sts_o,
  output logic [255:0]     chain_o
);
  import sha_pkg::*;

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  fill_q;
  logic [63:0] len_q;
  logic [5:0]  rnd_q;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned s);
    rotr = (x >> s) | (x << (32 - s));
  endfunction

  logic [31:0] w2, w15, sg0, sg1, wt, s0, s1, chv, mj, t1, t2;
  logic [3:0]  ti;

  // Schedule word and round function
  always_comb begin
    ti  = rnd_q[3:0];
    w2  = w_q[4'(ti - 4'd2)];
    w15 = w_q[4'(ti - 4'd15)];
    sg1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    sg0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    if (!rnd_q[5] && !rnd_q[4]) begin
      wt = w_q[ti];
    end else begin
      wt = sg1 + w_q[4'(ti - 4'd7)] + sg0 + w_q[ti];
    end
    s1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    chv = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    s0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + s1 + chv + RoundK[rnd_q] + wt;
    t2  = s0 + mj;
  end

  // Block buffer and working variables (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.put_byte) begin
      case (fill_q[1:0])
        2'd0:    w_q[fill_q[5:2]][31:24] <= cmd_i.put_data;
        2'd1:    w_q[fill_q[5:2]][23:16] <= cmd_i.put_data;
        2'd2:    w_q[fill_q[5:2]][15:8]  <= cmd_i.put_data;
        default: w_q[fill_q[5:2]][7:0]   <= cmd_i.put_data;
      endcase
    end
    if (cmd_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
    if (cmd_i.round) begin
      w_q[ti] <= wt;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // Chain value and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
      fill_q <= '0;
      len_q  <= '0;
      rnd_q  <= '0;
    end else begin
      if (cmd_i.put_byte) fill_q <= fill_q + 6'd1;
      if (cmd_i.add_len)  len_q  <= len_q + 64'd8;
      if (cmd_i.start)    rnd_q  <= '0;
      if (cmd_i.round)    rnd_q  <= rnd_q + 6'd1;
      if (cmd_i.finish) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
        fill_q <= '0;
        len_q  <= '0;
      end
    end
  end

  assign sts_o.fill       = fill_q;
  assign sts_o.bit_len    = len_q;
  assign sts_o.last_round = (rnd_q == 6'(NumRounds - 1));
  assign chain_o = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};

endmodule

// ----- hw/rtl/sha_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_byte_valid_i,
  input  logic             in_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       out_index_o,
  output sha_pkg::dp_cmd_t cmd_o,
  input  sha_pkg::dp_sts_t sts_i
);
  import sha_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StFold  = 3'd3;
  localparam logic [2:0] StPad   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       pad_q, pad_d;    // finishing a message
  logic       seen_q, seen_d;  // 0x80 already appended
  logic       wrap_q, wrap_d;  // 0x80 left no room for the length in this block
  logic [1:0] idx_q, idx_d;
  logic [2:0] lb;

  always_comb begin
    state_d = state_q;
    pad_d   = pad_q;
    seen_d  = seen_q;
    wrap_d  = wrap_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    lb = 3'(7 - 32'(sts_i.fill[2:0]));
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.put_byte = in_byte_valid_i;
          cmd_o.put_data = in_byte_i;
          cmd_o.add_len  = in_byte_valid_i;
          pad_d  = in_last_i;
          seen_d = 1'b0;
          wrap_d = 1'b0;
          if (in_byte_valid_i && sts_i.fill == 6'd63) state_d = StStart;
          else if (in_last_i) state_d = StPad;
        end
      end
      StStart: begin
        cmd_o.start = 1'b1;
        state_d = StRound;
      end
      StRound: begin
        cmd_o.round = 1'b1;
        if (sts_i.last_round) state_d = StFold;
      end
      StFold: begin
        cmd_o.finish = 1'b1;
        wrap_d = 1'b0;
        if (pad_q && seen_q && !wrap_q) begin
          idx_d = 2'd0;
          state_d = StOut;
        end else if (pad_q) state_d = StPad;
        else state_d = StIdle;
      end
      StPad: begin
        cmd_o.put_byte = 1'b1;
        seen_d = 1'b1;
        if (!seen_q) begin
          cmd_o.put_data = PadByte;
          wrap_d = (sts_i.fill >= LenOffset);
        end else if (sts_i.fill >= LenOffset && !wrap_q) begin
          cmd_o.put_data = sts_i.bit_len[8*lb +: 8];
        end else cmd_o.put_data = 8'h00;
        if (sts_i.fill == 6'd63) state_d = StStart;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            cmd_o.restart = 1'b1;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pad_q   <= 1'b0;
      seen_q  <= 1'b0;
      wrap_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      pad_q   <= pad_d;
      seen_q  <= seen_d;
      wrap_q  <= wrap_d;
      idx_q   <= idx_d;
    end
  end

  assign out_index_o = idx_q;

endmodule

// ----- hw/rtl/sha256_byte_stream_hasher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and emits the 256-bit digest as four 64-bit words.
// ----------------------------------------------------------------------------
// Input channel s_axis: one transfer per item; tdata holds the byte, tuser
// says whether the byte belongs to the message, tlast ends the message.
// Output channel m_axis: four transfers per message, H0/H1 first; tlast
// marks the fourth word, tuser carries its index.
// A byte that fills a 64-byte block is stored, the working variables
// are loaded, 64 rounds run on the single round unit doing one round
// per cycle, and the result is folded into the chaining value. The
// final item adds up to 72 padding bytes and one or two compressions,
// then the digest words, each held until taken. While the digest waits
// or rounds run, s_axis_tready is low. Reset returns the chaining value
// to the initial hash and clears the byte count and length.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] digest_word
  output logic [1:0]  m_axis_tuser,   // [1:0] word_index
  output logic        m_axis_tlast    // last_word
);
  import sha_pkg::*;

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [255:0]  chain;
  logic [1:0]    idx;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_byte_i(s_axis_tdata), .in_byte_valid_i(s_axis_tuser),
    .in_last_i(s_axis_tlast),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_index_o(idx), .cmd_o(cmd), .sts_i(sts)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .chain_o(chain)
  );

  // Select digest word, H0/H1 in the top of the chain vector
  assign m_axis_tdata = chain[255 - 64*idx -: 64];
  assign m_axis_tuser = idx;
  assign m_axis_tlast = (idx == 2'd3);

endmodule
